// ----- design/ede_pkg.sv -----
// Shared constants, codes and controller types of the edit distance engine.
package ede_pkg;

    localparam int CMD_W           = 2;
    localparam int SYMBOL_W        = 16;
    localparam int DIST_W          = 9;
    localparam int MAX_LEN_DEF     = 256;
    localparam int SYMBOL_BITS_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CELL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic fetch;
        logic update;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic finish;
        logic empty;
        logic row_end;
        logic last_row;
        logic out_free;
    } t_ctrl_status;

endpackage

// ----- design/ede_if.sv -----
// Valid/ready channel interfaces for symbol beats and result beats.
interface ede_in_if import ede_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [SYMBOL_W-1:0] symbol;

    modport source (output valid, output command, output symbol, input ready);
    modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface ede_out_if import ede_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

// ----- design/ede_ctrl.sv -----
// Sequencing state machine for loading, the row sweep and result hand-off.
module ede_ctrl import ede_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_status.finish) begin
                    n_state = i_status.empty ? S_DONE : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_CELL;
            end
            S_CELL: begin
                if (i_status.row_end) begin
                    n_state = i_status.last_row ? S_DONE : S_FETCH;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.in_ready = 1'b1;
            S_FETCH: o_cmd.fetch    = 1'b1;
            S_CELL:  o_cmd.update   = 1'b1;
            S_DONE:  o_cmd.emit     = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- design/ede_datapath.sv -----
// Symbol stores, single cost row and the cell update of the distance sweep.
module ede_datapath import ede_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ede_in_if.sink       i_in,
    ede_out_if.source    o_out,
    input  t_ctrl_cmd    i_cmd,
    output t_ctrl_status o_status
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SW = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
    localparam logic [LW-1:0] ONE     = LW'(1);

    logic [SW-1:0] first_mem  [MAX_LEN];
    logic [SW-1:0] second_mem [MAX_LEN];
    logic [LW-1:0] row_mem    [MAX_LEN];

    logic [LW-1:0] r_len1, r_len2;
    logic          r_drop;
    logic [LW-1:0] r_i, r_j, r_left, r_diag, r_above_mem;
    logic [SW-1:0] r_a, r_b;
    logic          r_out_valid;
    logic          r_ovf;
    logic [DIST_W-1:0] r_dist;

    logic          accept, wr1, wr2, drop;
    logic [LW-1:0] i_m1, j_m1, above, m1, m2, cost_new, res;
    logic [AW-1:0] rd_addr;
    logic [LW+DIST_W-1:0] res_wide;

    assign accept = i_in.valid && i_cmd.in_ready;
    assign wr1    = accept && (i_in.command == CMD_FIRST)  && (r_len1 != LEN_MAX);
    assign wr2    = accept && (i_in.command == CMD_SECOND) && (r_len2 != LEN_MAX);
    assign drop   = accept && (((i_in.command == CMD_FIRST)  && (r_len1 == LEN_MAX)) ||
                               ((i_in.command == CMD_SECOND) && (r_len2 == LEN_MAX)));

    assign i_m1    = r_i - ONE;
    assign j_m1    = r_j - ONE;
    assign rd_addr = i_cmd.fetch ? '0 : r_j[AW-1:0];

    // first row of the matrix is 0..n2, so it is never read back from memory
    assign above    = (r_i == ONE) ? r_j : r_above_mem;
    assign m1       = (r_left < above) ? r_left : above;
    assign m2       = (m1 < r_diag) ? m1 : r_diag;
    assign cost_new = (r_a == r_b) ? r_diag : m2 + ONE;

    assign res = (r_len1 == '0) ? r_len2 :
                 (r_len2 == '0) ? r_len1 : r_left;
    assign res_wide = {{DIST_W{1'b0}}, res};

    always_ff @(posedge i_clk) begin
        if (wr1) begin
            first_mem[r_len1[AW-1:0]] <= i_in.symbol[SW-1:0];
        end
        if (wr2) begin
            second_mem[r_len2[AW-1:0]] <= i_in.symbol[SW-1:0];
        end
        if (i_cmd.update) begin
            row_mem[j_m1[AW-1:0]] <= cost_new;
        end
        r_a         <= first_mem[i_m1[AW-1:0]];
        r_b         <= second_mem[rd_addr];
        r_above_mem <= row_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.command == CMD_FINISH)) begin
            r_i <= ONE;
        end else if (i_cmd.update && o_status.row_end) begin
            r_i <= r_i + ONE;
        end
        if (i_cmd.fetch) begin
            r_j    <= ONE;
            r_left <= r_i;
            r_diag <= i_m1;
        end else if (i_cmd.update) begin
            r_j    <= r_j + ONE;
            r_left <= cost_new;
            r_diag <= above;
        end
        if (i_cmd.emit) begin
            r_dist <= res_wide[DIST_W-1:0];
            r_ovf  <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1      <= '0;
            r_len2      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_len1 <= '0;
                r_len2 <= '0;
                r_drop <= 1'b0;
            end else begin
                if (wr1) begin
                    r_len1 <= r_len1 + ONE;
                end
                if (wr2) begin
                    r_len2 <= r_len2 + ONE;
                end
                if (drop) begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready     = i_cmd.in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_dist;
    assign o_out.overflow = r_ovf;

    assign o_status.finish   = i_in.valid && (i_in.command == CMD_FINISH);
    assign o_status.empty    = (r_len1 == '0) || (r_len2 == '0);
    assign o_status.row_end  = (r_j == r_len2);
    assign o_status.last_row = (r_i == r_len1);
    assign o_status.out_free = !r_out_valid || o_out.ready;

endmodule

// ----- design/edit_distance_engine.sv -----
// Edit distance engine: Levenshtein distance between two loaded symbol sequences.
// Input channel i_in carries a command and a symbol per beat: command 0 appends
// the symbol to the first sequence, 1 to the second, 2 finishes, 3 is ignored.
// Appends are taken one beat per cycle while the engine is idle; a symbol past
// MAX_LEN is dropped and raises the overflow flag. Only the low SYMBOL_BITS bits
// of a symbol count. A finish beat starts a row-by-row sweep over one stored cost
// row: each row of the first sequence has a fetch step and then one cell update
// per symbol of the second, after which the result beat is emitted; the sweep is
// skipped when either sequence is empty. No beat is taken during the sweep.
// Output channel o_out carries distance and overflow from a result register;
// appends are still taken while that beat waits, and a later finish holds in
// its last step until the receiver takes the pending beat. Emitting clears
// both lengths and the flag.
// Reset (synchronous, active low) empties both sequences, clears the flag and
// drops any pending result; store contents need no clearing.
module edit_distance_engine import ede_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ede_in_if.sink    i_in,
    ede_out_if.source o_out
);

    t_ctrl_cmd    ctrl_cmd;
    t_ctrl_status ctrl_status;

    ede_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (ctrl_status),
        .o_cmd    (ctrl_cmd)
    );

    ede_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (ctrl_cmd),
        .o_status (ctrl_status)
    );

endmodule
